// ===== rtl/assert_macros.svh =====
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPHR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sphr: implication check failed");
`define SPHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sphr: next-cycle check failed");
`else
`define SPHR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPHR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/sphr_pkg.sv =====
`default_nettype none
package sphr_pkg;

   // run modes
   localparam logic [2:0] MODE_AUTO   = 3'd0;
   localparam logic [2:0] MODE_OFF    = 3'd1;
   localparam logic [2:0] MODE_FORCED = 3'd2;
   localparam logic [2:0] MODE_PIDOFF = 3'd4;

   // status codes
   localparam logic [2:0] STAT_SAFETY   = 3'd0;
   localparam logic [2:0] STAT_OFF      = 3'd1;
   localparam logic [2:0] STAT_PIDOFF   = 3'd2;
   localparam logic [2:0] STAT_FORCED   = 3'd3;
   localparam logic [2:0] STAT_HOLD     = 3'd4;
   localparam logic [2:0] STAT_DEADBAND = 3'd5;
   localparam logic [2:0] STAT_REGULATE = 3'd6;

   // register indexes
   localparam logic [2:0] REG_RUN_MODE     = 3'd0;
   localparam logic [2:0] REG_SETPOINT     = 3'd1;
   localparam logic [2:0] REG_DEADBAND     = 3'd2;
   localparam logic [2:0] REG_GAIN_P       = 3'd3;
   localparam logic [2:0] REG_GAIN_I       = 3'd4;
   localparam logic [2:0] REG_GAIN_D       = 3'd5;
   localparam logic [2:0] REG_SLEW_RATE    = 3'd6;
   localparam logic [2:0] REG_FORCED_LEVEL = 3'd7;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [22:0] PCT_FULL   = 23'd6553600;
   localparam logic [22:0] SLEW_FLOOR = 23'd6554;
   localparam int          INTEG_LIM  = 5000000;

   // serial arithmetic unit
   localparam int MA_W       = 52;
   localparam int MB_W       = 24;
   localparam int REM_W      = 10;
   localparam int CNT_W      = 6;
   localparam int MUL_STEPS  = MB_W;
   localparam int DIV_STEPS  = MA_W;
   localparam int SUM_W      = 54;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INTEG_MUL,
      ST_P_MUL,
      ST_I_MUL,
      ST_I_DIV,
      ST_D_MUL,
      ST_D_SCALE,
      ST_D_DIV,
      ST_LIMIT,
      ST_SLEW_MUL,
      ST_SLEW_DIV,
      ST_PWR_MUL,
      ST_PWR_DIV,
      ST_DONE
   } ctrl_state_type;

endpackage
`default_nettype wire

// ===== rtl/sphr_if.sv =====
`default_nettype none
interface sphr_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        now_ms;
   logic signed [15:0] grid_raw_w;
   logic signed [15:0] grid_filtered_w;
   logic               filtered_valid;
   logic               safety_trip;
   modport source (output valid, now_ms, grid_raw_w, grid_filtered_w, filtered_valid,
                   safety_trip, input ready);
   modport sink (input valid, now_ms, grid_raw_w, grid_filtered_w, filtered_valid,
                 safety_trip, output ready);
endinterface

interface sphr_rsp_if;
   logic               valid;
   logic               ready;
   logic [22:0]        drive_percent;
   logic [2:0]         status;
   logic               injecting;
   logic signed [16:0] error_w;
   logic [15:0]        heater_power_w;
   modport source (output valid, drive_percent, status, injecting, error_w, heater_power_w,
                   input ready);
   modport sink (input valid, drive_percent, status, injecting, error_w, heater_power_w,
                 output ready);
endinterface

interface sphr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sphr_pkg::CSR_IDX_W-1:0]      index;
   logic [sphr_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/surplus_pid_heater_regulator_unit.sv =====
`default_nettype none
`include "assert_macros.svh"
// Surplus heater regulator: one result word per tick word, one tick in flight.
// A tick runs through a single bit-serial shift-add multiplier / restoring
// divider (one bit per cycle). A multiply runs a load step, one shift-add
// step per bit of the 24-bit multiplier and a finish step; a divide runs a
// load step, one step per bit of the 52-bit dividend and a finish step.
// Safety/off/pid-off/hold/deadband ticks compute heater power only. Forced
// mode computes a slew step and power, and a regulating tick computes
// integral, P, I/1000, D*1000/elapsed, limit, slew and power. The next tick
// can be accepted in the cycle after the result word is loaded, even if
// that word is still held in the output register. The sequencer only stalls
// in its last state while the output register holds an unaccepted word.
// Configuration writes are always taken (csr ready is tied high) and must
// only happen while the block is idle.
module surplus_pid_heater_regulator_unit #(
   parameter int unsigned HEATER_MAX_W = 1500
) (
   input  wire logic clock,
   input  wire logic reset,
   sphr_req_if.sink   req_ch,
   sphr_rsp_if.source rsp_ch,
   sphr_csr_if.sink   csr_ch
);

   localparam int MA_W  = sphr_pkg::MA_W;
   localparam int MB_W  = sphr_pkg::MB_W;
   localparam int SUM_W = sphr_pkg::SUM_W;

   // ---------------- configuration registers ----------------
   logic [2:0]         run_mode_ff;
   logic signed [15:0] setpoint_ff;
   logic [14:0]        deadband_ff;
   logic [23:0]        gain_p_ff, gain_i_ff, gain_d_ff;
   logic [22:0]        slew_rate_ff, forced_level_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff     <= sphr_pkg::MODE_AUTO;
         setpoint_ff     <= '0;
         deadband_ff     <= 15'd30;
         gain_p_ff       <= 24'd20972;
         gain_i_ff       <= 24'd2097;
         gain_d_ff       <= '0;
         slew_rate_ff    <= 23'd327680;
         forced_level_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            sphr_pkg::REG_RUN_MODE:     run_mode_ff     <= csr_ch.data[2:0];
            sphr_pkg::REG_SETPOINT:     setpoint_ff     <= $signed(csr_ch.data[15:0]);
            sphr_pkg::REG_DEADBAND:     deadband_ff     <= csr_ch.data[14:0];
            sphr_pkg::REG_GAIN_P:       gain_p_ff       <= csr_ch.data;
            sphr_pkg::REG_GAIN_I:       gain_i_ff       <= csr_ch.data;
            sphr_pkg::REG_GAIN_D:       gain_d_ff       <= csr_ch.data;
            sphr_pkg::REG_SLEW_RATE:    slew_rate_ff    <= csr_ch.data[22:0];
            sphr_pkg::REG_FORCED_LEVEL: forced_level_ff <= csr_ch.data[22:0];
            default: ;
         endcase
      end
   end

   // ---------------- regulator state ----------------
   sphr_pkg::ctrl_state_type state_ff, state_in;

   logic [31:0]          last_time_ff;
   logic                 time_valid_ff;
   logic signed [23:0]   integ_ff;
   logic signed [17:0]   prior_ff;
   logic [22:0]          held_ff;

   // per-tick working registers
   logic [7:0]               elapsed_ff;
   logic signed [16:0]       err_ff;
   logic                     over_ff;
   logic                     inj_ff;
   logic [2:0]               status_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [22:0]              tgt_ff;
   logic [15:0]              power_ff;

   // serial arithmetic unit
   logic                              run_ff;
   logic [sphr_pkg::CNT_W-1:0]        cnt_ff;
   logic [MA_W-1:0]                   ma_ff, acc_ff;
   logic [MB_W-1:0]                   mb_ff;
   logic [sphr_pkg::REM_W-1:0]        rem_ff, dsr_ff;

   // output register
   logic               rsp_valid_ff;
   logic [22:0]        rsp_drive_ff;
   logic [2:0]         rsp_status_ff;
   logic               rsp_inj_ff;
   logic signed [16:0] rsp_err_ff;
   logic [15:0]        rsp_power_ff;

   // ---------------- tick decode ----------------
   logic               req_acc;
   logic [31:0]        dt;
   logic [7:0]         elapsed_now;
   logic signed [15:0] meas;
   logic signed [16:0] err_now;
   logic [16:0]        mag_now;
   logic               clr_now;
   logic               band_now;

   assign req_ch.ready = (state_ff == sphr_pkg::ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;

   always_comb begin
      dt = req_ch.now_ms - last_time_ff;
      if (!time_valid_ff || dt > 32'd250) begin
         elapsed_now = 8'd250;
      end else if (dt < 32'd100) begin
         elapsed_now = 8'd100;
      end else begin
         elapsed_now = dt[7:0];
      end
      meas     = req_ch.filtered_valid ? req_ch.grid_filtered_w : req_ch.grid_raw_w;
      err_now  = 17'(setpoint_ff) - 17'(meas);
      mag_now  = err_now[16] ? 17'(-err_now) : 17'(err_now);
      band_now = (mag_now <= {2'b00, deadband_ff});
      clr_now  = req_ch.safety_trip || (run_mode_ff == sphr_pkg::MODE_OFF)
                 || (run_mode_ff == sphr_pkg::MODE_PIDOFF);
   end

   // ---------------- operand select (state outputs) ----------------
   logic                    is_op, is_div, ld, fin, term_neg;
   logic [MA_W-1:0]         op_a, dvd;
   logic [MB_W-1:0]         op_b;
   logic [sphr_pkg::REM_W-1:0] dsr;
   logic [16:0]             err_mag;
   logic [23:0]             integ_mag;
   logic signed [17:0]      derr;
   logic [17:0]             derr_mag;
   logic [22:0]             rate_fl;

   always_comb begin
      err_mag   = err_ff[16] ? 17'(-err_ff) : 17'(err_ff);
      integ_mag = integ_ff[23] ? 24'(-integ_ff) : 24'(integ_ff);
      derr      = 18'(err_ff) - prior_ff;
      derr_mag  = derr[17] ? 18'(-derr) : 18'(derr);
      rate_fl   = (slew_rate_ff < sphr_pkg::SLEW_FLOOR) ? sphr_pkg::SLEW_FLOOR : slew_rate_ff;
   end

   always_comb begin
      is_op    = 1'b1;
      is_div   = 1'b0;
      term_neg = 1'b0;
      op_a     = '0;
      op_b     = '0;
      dvd      = '0;
      dsr      = '0;
      case (state_ff)
         sphr_pkg::ST_INTEG_MUL: begin
            op_a = MA_W'(err_mag);
            op_b = MB_W'(elapsed_ff);
         end
         sphr_pkg::ST_P_MUL: begin
            op_a     = MA_W'(gain_p_ff);
            op_b     = MB_W'(err_mag);
            term_neg = err_ff[16];
         end
         sphr_pkg::ST_I_MUL: begin
            op_a = MA_W'(gain_i_ff);
            op_b = integ_mag;
         end
         sphr_pkg::ST_I_DIV: begin
            is_div   = 1'b1;
            dvd      = acc_ff;
            dsr      = 10'd1000;
            term_neg = integ_ff[23];
         end
         sphr_pkg::ST_D_MUL: begin
            op_a = MA_W'(gain_d_ff);
            op_b = MB_W'(derr_mag);
         end
         sphr_pkg::ST_D_SCALE: begin
            op_a = acc_ff;
            op_b = MB_W'(1000);
         end
         sphr_pkg::ST_D_DIV: begin
            is_div   = 1'b1;
            dvd      = acc_ff;
            dsr      = 10'(elapsed_ff);
            term_neg = derr[17];
         end
         sphr_pkg::ST_SLEW_MUL: begin
            op_a = MA_W'(rate_fl);
            op_b = MB_W'(elapsed_ff);
         end
         sphr_pkg::ST_SLEW_DIV: begin
            is_div = 1'b1;
            dvd    = acc_ff;
            dsr    = 10'd1000;
         end
         sphr_pkg::ST_PWR_MUL: begin
            op_a = MA_W'(HEATER_MAX_W);
            op_b = MB_W'(held_ff);
         end
         sphr_pkg::ST_PWR_DIV: begin
            is_div = 1'b1;
            dvd    = acc_ff >> 16;       // / 65536 then / 100
            dsr    = 10'd100;
         end
         default: is_op = 1'b0;
      endcase
      ld  = is_op && !run_ff;
      fin = run_ff && (cnt_ff == '0);
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sphr_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (clr_now) begin
                  state_in = sphr_pkg::ST_PWR_MUL;
               end else if (run_mode_ff == sphr_pkg::MODE_FORCED) begin
                  state_in = sphr_pkg::ST_SLEW_MUL;
               end else if (run_mode_ff != sphr_pkg::MODE_AUTO || band_now) begin
                  state_in = sphr_pkg::ST_PWR_MUL;
               end else begin
                  state_in = sphr_pkg::ST_INTEG_MUL;
               end
            end
         end
         sphr_pkg::ST_INTEG_MUL: if (fin) state_in = sphr_pkg::ST_P_MUL;
         sphr_pkg::ST_P_MUL:     if (fin) state_in = sphr_pkg::ST_I_MUL;
         sphr_pkg::ST_I_MUL:     if (fin) state_in = sphr_pkg::ST_I_DIV;
         sphr_pkg::ST_I_DIV:     if (fin) state_in = sphr_pkg::ST_D_MUL;
         sphr_pkg::ST_D_MUL:     if (fin) state_in = sphr_pkg::ST_D_SCALE;
         sphr_pkg::ST_D_SCALE:   if (fin) state_in = sphr_pkg::ST_D_DIV;
         sphr_pkg::ST_D_DIV:     if (fin) state_in = sphr_pkg::ST_LIMIT;
         sphr_pkg::ST_LIMIT:     state_in = sphr_pkg::ST_SLEW_MUL;
         sphr_pkg::ST_SLEW_MUL:  if (fin) state_in = sphr_pkg::ST_SLEW_DIV;
         sphr_pkg::ST_SLEW_DIV:  if (fin) state_in = sphr_pkg::ST_PWR_MUL;
         sphr_pkg::ST_PWR_MUL:   if (fin) state_in = sphr_pkg::ST_PWR_DIV;
         sphr_pkg::ST_PWR_DIV:   if (fin) state_in = sphr_pkg::ST_DONE;
         sphr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = sphr_pkg::ST_IDLE;
         end
         default: state_in = sphr_pkg::ST_IDLE;
      endcase
   end

   // ---------------- serial unit step ----------------
   logic [sphr_pkg::REM_W:0]   div_rs;
   logic                       div_ge;
   logic [MA_W-1:0]            mul_acc;

   always_comb begin
      div_rs  = {rem_ff, acc_ff[MA_W-1]};
      div_ge  = (div_rs >= {1'b0, dsr_ff});
      mul_acc = acc_ff + (mb_ff[0] ? ma_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (ld) begin
         run_ff <= 1'b1;
         if (is_div) begin
            cnt_ff <= sphr_pkg::CNT_W'(sphr_pkg::DIV_STEPS);
            acc_ff <= dvd;
            rem_ff <= '0;
            dsr_ff <= dsr;
         end else begin
            cnt_ff <= sphr_pkg::CNT_W'(sphr_pkg::MUL_STEPS);
            ma_ff  <= op_a;
            mb_ff  <= op_b;
            acc_ff <= '0;
         end
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
            if (is_div) begin
               // restoring divide, one quotient bit per cycle
               rem_ff <= div_ge ? sphr_pkg::REM_W'(div_rs - {1'b0, dsr_ff})
                                : sphr_pkg::REM_W'(div_rs);
               acc_ff <= {acc_ff[MA_W-2:0], div_ge};
            end else begin
               acc_ff <= mul_acc;
               ma_ff  <= ma_ff << 1;
               mb_ff  <= mb_ff >> 1;
            end
         end
      end
   end

   // ---------------- result handling ----------------
   logic signed [25:0]      ip, isum;
   logic signed [SUM_W-1:0] term, h16, lim, tclamp;
   logic [23:0]             slew_hi;
   logic signed [24:0]      slew_lo;
   logic [22:0]             step, held_new, forced_cl;
   logic                    rsp_load;

   always_comb begin
      ip   = $signed({2'b00, acc_ff[23:0]});
      isum = 26'(integ_ff) + (err_ff[16] ? -ip : ip);
      if (isum > 26'sd5000000) begin
         isum = 26'(sphr_pkg::INTEG_LIM);
      end else if (isum < -26'sd5000000) begin
         isum = -26'(sphr_pkg::INTEG_LIM);
      end

      term = $signed({2'b00, acc_ff});
      if (term_neg) term = -term;

      // over-setpoint limit, then 0..100 percent clamp (Q20)
      h16    = $signed(SUM_W'({held_ff, 4'b0000}));
      lim    = h16 - (SUM_W'(1) <<< 21);
      tclamp = sum_ff;
      if (over_ff && tclamp > lim) tclamp = lim;
      if (tclamp < 0) tclamp = '0;
      if (tclamp > (SUM_W'(100) <<< 20)) tclamp = SUM_W'(100) <<< 20;

      step    = acc_ff[22:0];
      slew_hi = {1'b0, held_ff} + {1'b0, step};
      slew_lo = $signed({2'b00, held_ff}) - $signed({2'b00, step});
      if ({1'b0, tgt_ff} > slew_hi) begin
         held_new = slew_hi[22:0];
      end else if ($signed({2'b00, tgt_ff}) < slew_lo) begin
         held_new = slew_lo[22:0];
      end else begin
         held_new = tgt_ff;
      end

      forced_cl = (forced_level_ff > sphr_pkg::PCT_FULL) ? sphr_pkg::PCT_FULL
                                                        : forced_level_ff;

      // output register takes the finished word when it is free or draining
      rsp_load = (state_ff == sphr_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sphr_pkg::ST_IDLE;
         last_time_ff  <= '0;
         time_valid_ff <= 1'b0;
         integ_ff      <= '0;
         prior_ff      <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            sphr_pkg::ST_IDLE: begin
               if (req_acc) begin
                  elapsed_ff <= elapsed_now;
                  inj_ff     <= 1'b0;
                  err_ff     <= '0;
                  over_ff    <= (err_now < -$signed({2'b00, deadband_ff}));
                  sum_ff     <= $signed(SUM_W'({held_ff, 4'b0000}));
                  if (clr_now) begin
                     last_time_ff  <= '0;
                     time_valid_ff <= 1'b0;
                     integ_ff      <= '0;
                     prior_ff      <= '0;
                     held_ff       <= '0;
                     status_ff     <= req_ch.safety_trip ? sphr_pkg::STAT_SAFETY :
                                      (run_mode_ff == sphr_pkg::MODE_OFF) ?
                                      sphr_pkg::STAT_OFF : sphr_pkg::STAT_PIDOFF;
                  end else begin
                     last_time_ff  <= req_ch.now_ms;
                     time_valid_ff <= 1'b1;
                     case (run_mode_ff)
                        sphr_pkg::MODE_FORCED: begin
                           status_ff <= sphr_pkg::STAT_FORCED;
                           tgt_ff    <= forced_cl;
                        end
                        sphr_pkg::MODE_AUTO: begin
                           err_ff <= err_now;
                           if (band_now) begin
                              status_ff <= sphr_pkg::STAT_DEADBAND;
                              prior_ff  <= 18'(err_now);
                           end else begin
                              status_ff <= sphr_pkg::STAT_REGULATE;
                              inj_ff    <= (meas < -$signed({1'b0, deadband_ff}));
                           end
                        end
                        default: status_ff <= sphr_pkg::STAT_HOLD;
                     endcase
                  end
               end
            end
            sphr_pkg::ST_INTEG_MUL: if (fin) integ_ff <= 24'(isum);
            sphr_pkg::ST_P_MUL, sphr_pkg::ST_I_DIV, sphr_pkg::ST_D_DIV: begin
               if (fin) sum_ff <= sum_ff + term;
            end
            sphr_pkg::ST_LIMIT: begin
               tgt_ff   <= tclamp[26:4];
               prior_ff <= 18'(err_ff);
            end
            sphr_pkg::ST_SLEW_DIV: if (fin) held_ff <= held_new;
            sphr_pkg::ST_PWR_DIV:  if (fin) power_ff <= acc_ff[15:0];
            sphr_pkg::ST_DONE: begin
               if (rsp_load) begin
                  rsp_drive_ff  <= held_ff;
                  rsp_status_ff <= status_ff;
                  rsp_inj_ff    <= inj_ff;
                  rsp_err_ff    <= err_ff;
                  rsp_power_ff  <= power_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.drive_percent  = rsp_drive_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.injecting      = rsp_inj_ff;
   assign rsp_ch.error_w        = rsp_err_ff;
   assign rsp_ch.heater_power_w = rsp_power_ff;

   // ---------------- checks ----------------
   `SPHR_ASSERT_IMPL(a_held_range, clock, reset, 1'b1, held_ff <= sphr_pkg::PCT_FULL)
   `SPHR_ASSERT_IMPL(a_integ_range, clock, reset, 1'b1, (integ_ff <= 24'sd5000000) && (integ_ff >= -24'sd5000000))
   `SPHR_ASSERT_NEXT(a_clear, clock, reset, req_acc && clr_now, (held_ff == '0) && (integ_ff == '0) && !time_valid_ff)
   `SPHR_ASSERT_IMPL(a_unit_busy, clock, reset, run_ff, (state_ff != sphr_pkg::ST_IDLE) && (state_ff != sphr_pkg::ST_DONE))

endmodule
`default_nettype wire
